// File: rtl/assert_macros.svh
// Assertion macros used by the checker file iwcs_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/iwcs_pkg.sv
// Types, constants and helpers for the inverter wheel command supervisor.
// No dependencies.
package iwcs_pkg;

  localparam int WHEELS       = 4;
  localparam int WHEEL_W      = 2;
  localparam int WHEEL_FAULT_W = 11;
  localparam int GEN_W        = 6;
  localparam int SPEED_W      = 15;
  localparam int TORQUE_W     = 15;
  localparam int SLEW_W       = 23;
  localparam int VALUE_W      = 16;
  localparam int FRAC_BITS    = 8;
  localparam int CMD_W        = SPEED_W + FRAC_BITS;
  localparam int SUM_W        = ((CMD_W > SLEW_W) ? CMD_W : SLEW_W) + 1;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [SPEED_W-1:0]  DEFAULT_RUN_SPEED = SPEED_W'(1000);
  localparam logic [TORQUE_W-1:0] DEFAULT_TORQUE    = TORQUE_W'(100);
  localparam logic [WHEELS-1:0]   RST_ACTIVE_MASK   = '0;
  localparam logic [SPEED_W-1:0]  RST_MAX_SPEED     = SPEED_W'(20000);
  localparam logic [TORQUE_W-1:0] RST_MAX_TORQUE    = TORQUE_W'(210);
  localparam logic [SLEW_W-1:0]   RST_SLEW_STEP     = SLEW_W'(25600);

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_ERROR      = 3'd1,
    ACT_ARM        = 3'd2,
    ACT_DISARM     = 3'd3,
    ACT_SET_RUN    = 3'd4,
    ACT_TOGGLE_RUN = 3'd5,
    ACT_SET_SPEED  = 3'd6,
    ACT_SET_TORQUE = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_MASK = 2'd0,
    REG_MAX_SPEED   = 2'd1,
    REG_MAX_TORQUE  = 2'd2,
    REG_SLEW_STEP   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WHEELS-1:0]   active_mask;
    logic [SPEED_W-1:0]  max_speed;
    logic [TORQUE_W-1:0] max_torque;
    logic [SLEW_W-1:0]   slew_step;
  } cfg_t;

  typedef struct packed {
    logic                fire;
    action_t             action;
    logic                sel;
    logic                run_flag;
    logic                fault_hit;
    logic [SPEED_W-1:0]  speed_val;
    logic [TORQUE_W-1:0] torque_val;
  } wheel_ev_t;

  typedef struct packed {
    logic                enable;
    logic                reset_error;
    logic                ack_error;
    logic [SPEED_W-1:0]  speed;
    logic [TORQUE_W-1:0] torque;
    logic                fault;
  } wheel_res_t;

  function automatic logic gen_hit(input logic [WHEEL_W-1:0] w, input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] mask;
    mask = (w < WHEEL_W'(2)) ? 6'b001111 : 6'b110011;
    return |(g & mask);
  endfunction

  function automatic logic [VALUE_W-2:0] clamp_value(input logic signed [VALUE_W-1:0] v,
                                                     input logic [VALUE_W-2:0] hi);
    logic [VALUE_W-2:0] mag;
    mag = v[VALUE_W-2:0];
    if (v[VALUE_W-1]) return '0;
    return (mag > hi) ? hi : mag;
  endfunction

endpackage

// File: rtl/inverter_wheel_command_supervisor.sv
// Wheel command supervisor for four motor inverters: input register, per-wheel
// state and setpoint logic, setpoint output register. Takes one event transaction
// per cycle while event_ready is high; a tick's setpoint is loaded into the output
// register at the edge that takes the tick out of the input register; other events
// yield nothing. A stalled setpoint holds back only the next tick.
// Depends on iwcs_pkg, iwcs_regs and iwcs_wheel.
module inverter_wheel_command_supervisor import iwcs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [DATA_W-1:0]           pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready,
  input  logic                        event_valid,
  output logic                        event_ready,
  input  logic [2:0]                  action,
  input  logic [WHEEL_W-1:0]          wheel,
  input  logic                        run_flag,
  input  logic signed [VALUE_W-1:0]   value,
  input  logic [WHEELS*WHEEL_FAULT_W-1:0] wheel_faults,
  input  logic [GEN_W-1:0]            general_faults,
  output logic                        setpoint_valid,
  input  logic                        setpoint_ready,
  output logic [WHEEL_W-1:0]          out_wheel,
  output logic                        status,
  output logic                        enable,
  output logic                        reset_error,
  output logic                        ack_error,
  output logic [SPEED_W-1:0]          speed_setpoint,
  output logic [TORQUE_W-1:0]         torque_pos,
  output logic signed [VALUE_W-1:0]   torque_neg,
  output logic                        fault_latched
);

  cfg_t cfg;

  logic                        s_valid;
  action_t                     s_action;
  logic [WHEEL_W-1:0]          s_wheel;
  logic                        s_run_flag;
  logic signed [VALUE_W-1:0]   s_value;
  logic [WHEELS*WHEEL_FAULT_W-1:0] s_faults;
  logic [GEN_W-1:0]            s_gen;
  logic                        s_adv;
  logic                        is_tick;

  logic [SPEED_W-1:0]          speed_val;
  logic [TORQUE_W-1:0]         torque_val;
  wheel_ev_t                   ev [WHEELS];
  wheel_res_t                  res [WHEELS];
  wheel_res_t                  sel_res;
  logic                        sel_active;

  iwcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign is_tick     = (s_action == ACT_TICK);
  assign s_adv       = s_valid && (!is_tick || !setpoint_valid || setpoint_ready);
  assign event_ready = !s_valid || s_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (event_ready) begin
      s_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_ready && event_valid) begin
      s_action   <= action_t'(action);
      s_wheel    <= wheel;
      s_run_flag <= run_flag;
      s_value    <= value;
      s_faults   <= wheel_faults;
      s_gen      <= general_faults;
    end
  end

  assign speed_val  = clamp_value(s_value, cfg.max_speed);
  assign torque_val = clamp_value(s_value, cfg.max_torque);

  for (genvar k = 0; k < WHEELS; k++) begin : g_wheel
    assign ev[k].fire       = s_adv;
    assign ev[k].action     = s_action;
    assign ev[k].sel        = (s_wheel == WHEEL_W'(k));
    assign ev[k].run_flag   = s_run_flag;
    assign ev[k].fault_hit  = (|s_faults[k*WHEEL_FAULT_W +: WHEEL_FAULT_W]) ||
                              gen_hit(WHEEL_W'(k), s_gen);
    assign ev[k].speed_val  = speed_val;
    assign ev[k].torque_val = torque_val;

    iwcs_wheel u_wheel (
      .clk       (clk),
      .rst       (rst),
      .active    (cfg.active_mask[k]),
      .slew_step (cfg.slew_step),
      .ev        (ev[k]),
      .res       (res[k])
    );
  end

  assign sel_res    = res[s_wheel];
  assign sel_active = cfg.active_mask[s_wheel];

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_valid <= 1'b0;
    end else if (s_adv && is_tick) begin
      setpoint_valid <= 1'b1;
    end else if (setpoint_ready) begin
      setpoint_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && is_tick) begin
      out_wheel <= s_wheel;
      status    <= !sel_active;
      if (sel_active) begin
        enable         <= sel_res.enable;
        reset_error    <= sel_res.reset_error;
        ack_error      <= sel_res.ack_error;
        speed_setpoint <= sel_res.speed;
        torque_pos     <= sel_res.torque;
        torque_neg     <= VALUE_W'(-$signed({1'b0, sel_res.torque}));
        fault_latched  <= sel_res.fault;
      end else begin
        enable         <= 1'b0;
        reset_error    <= 1'b0;
        ack_error      <= 1'b0;
        speed_setpoint <= '0;
        torque_pos     <= '0;
        torque_neg     <= '0;
        fault_latched  <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/iwcs_regs.sv
// Configuration register file on an APB-style port.
// Depends on iwcs_pkg.
module iwcs_regs import iwcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_mask <= RST_ACTIVE_MASK;
      cfg.max_speed   <= RST_MAX_SPEED;
      cfg.max_torque  <= RST_MAX_TORQUE;
      cfg.slew_step   <= RST_SLEW_STEP;
    end else if (wr) begin
      unique case (idx)
        REG_ACTIVE_MASK: cfg.active_mask <= pwdata[WHEELS-1:0];
        REG_MAX_SPEED:   cfg.max_speed   <= pwdata[SPEED_W-1:0];
        REG_MAX_TORQUE:  cfg.max_torque  <= pwdata[TORQUE_W-1:0];
        REG_SLEW_STEP:   cfg.slew_step   <= pwdata[SLEW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACTIVE_MASK: prdata = DATA_W'(cfg.active_mask);
      REG_MAX_SPEED:   prdata = DATA_W'(cfg.max_speed);
      REG_MAX_TORQUE:  prdata = DATA_W'(cfg.max_torque);
      REG_SLEW_STEP:   prdata = DATA_W'(cfg.slew_step);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/iwcs_wheel.sv
// State and event logic of one wheel: flags, limits and speed slew.
// Depends on iwcs_pkg.
module iwcs_wheel import iwcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              active,
  input  logic [SLEW_W-1:0] slew_step,
  input  wheel_ev_t         ev,
  output wheel_res_t        res
);

  logic                armed;
  logic                fault_latch;
  logic                running;
  logic                ack_pending;
  logic                reset_pending;
  logic [SPEED_W-1:0]  run_speed;
  logic [TORQUE_W-1:0] torque_limit;
  logic [CMD_W-1:0]    cmd_speed;
  logic [CMD_W-1:0]    cmd_speed_next;

  logic                drive;
  logic [CMD_W-1:0]    target;
  logic [SUM_W-1:0]    up;
  logic [SUM_W-1:0]    gap;
  logic                upd;

  assign drive  = armed && !fault_latch;
  assign target = (running && drive) ? {run_speed, FRAC_BITS'(0)} : '0;
  assign up     = SUM_W'(cmd_speed) + SUM_W'(slew_step);
  assign gap    = SUM_W'(cmd_speed) - SUM_W'(target);

  always_comb begin
    cmd_speed_next = cmd_speed;
    if (cmd_speed < target) begin
      cmd_speed_next = (up < SUM_W'(target)) ? up[CMD_W-1:0] : target;
    end else if (cmd_speed > target) begin
      cmd_speed_next = (gap > SUM_W'(slew_step)) ?
                       CMD_W'(SUM_W'(cmd_speed) - SUM_W'(slew_step)) : target;
    end
  end

  assign res.enable      = drive;
  assign res.reset_error = reset_pending;
  assign res.ack_error   = ack_pending;
  assign res.speed       = cmd_speed_next[CMD_W-1:FRAC_BITS];
  assign res.torque      = torque_limit;
  assign res.fault       = fault_latch;

  assign upd = ev.fire && active;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      fault_latch   <= 1'b0;
      running       <= 1'b0;
      ack_pending   <= 1'b0;
      reset_pending <= 1'b0;
      run_speed     <= DEFAULT_RUN_SPEED;
      torque_limit  <= DEFAULT_TORQUE;
      cmd_speed     <= '0;
    end else if (upd) begin
      unique case (ev.action)
        ACT_TICK: begin
          if (ev.sel) begin
            cmd_speed     <= cmd_speed_next;
            ack_pending   <= 1'b0;
            reset_pending <= 1'b0;
          end
        end
        ACT_ERROR: begin
          if (ev.fault_hit && !fault_latch) begin
            fault_latch <= 1'b1;
            running     <= 1'b0;
          end
        end
        ACT_ARM: begin
          if (ev.sel) begin
            fault_latch   <= 1'b0;
            ack_pending   <= 1'b1;
            reset_pending <= 1'b1;
            armed         <= 1'b1;
          end
        end
        ACT_DISARM: begin
          if (ev.sel) begin
            running <= 1'b0;
            armed   <= 1'b0;
          end
        end
        ACT_SET_RUN: begin
          if (ev.sel) running <= ev.run_flag;
        end
        ACT_TOGGLE_RUN: begin
          if (ev.sel) running <= !running;
        end
        ACT_SET_SPEED: begin
          if (ev.sel) run_speed <= ev.speed_val;
        end
        ACT_SET_TORQUE: begin
          if (ev.sel) torque_limit <= ev.torque_val;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/iwcs_checker.sv
// Port-level checks on the setpoint channel of the supervisor, bound to the top.
// Depends on iwcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iwcs_checker import iwcs_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      setpoint_valid,
  input logic                      setpoint_ready,
  input logic [WHEEL_W-1:0]        out_wheel,
  input logic                      status,
  input logic                      enable,
  input logic [SPEED_W-1:0]        speed_setpoint,
  input logic [TORQUE_W-1:0]       torque_pos,
  input logic signed [VALUE_W-1:0] torque_neg,
  input logic                      fault_latched
);

  logic                      inactive_clean;
  logic                      neg_match;
  logic                      stalled;
  logic [WHEEL_W+SPEED_W+TORQUE_W+1:0] payload;
  logic signed [VALUE_W-1:0] neg_expect;

  assign neg_expect     = VALUE_W'(-$signed({1'b0, torque_pos}));
  assign neg_match      = (torque_neg == neg_expect);
  assign inactive_clean = !enable && !fault_latched && (speed_setpoint == '0) &&
                          (torque_pos == '0);
  assign stalled        = setpoint_valid && !setpoint_ready;
  assign payload        = {out_wheel, status, enable, speed_setpoint, torque_pos};

  `ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !setpoint_valid)
  `ASSERT_NEXT(a_stall_holds, clk, rst, stalled, setpoint_valid && $stable(payload))
  `ASSERT_IMPLY(a_inactive_zero, clk, rst, setpoint_valid && status, inactive_clean)
  `ASSERT_IMPLY(a_torque_neg, clk, rst, setpoint_valid, neg_match)
  `ASSERT_IMPLY(a_enable_unfaulted, clk, rst, setpoint_valid && enable, !fault_latched)

endmodule

bind inverter_wheel_command_supervisor iwcs_checker u_iwcs_checker (
  .clk            (clk),
  .rst            (rst),
  .setpoint_valid (setpoint_valid),
  .setpoint_ready (setpoint_ready),
  .out_wheel      (out_wheel),
  .status         (status),
  .enable         (enable),
  .speed_setpoint (speed_setpoint),
  .torque_pos     (torque_pos),
  .torque_neg     (torque_neg),
  .fault_latched  (fault_latched)
);

// File: tb/tb_top.sv
// Self-checking testbench for inverter_wheel_command_supervisor: a queue-fed
// event driver, a setpoint monitor and an event-level model of the wheel state.
// Depends on iwcs_pkg and the supervisor RTL.
module tb_top;
  import iwcs_pkg::*;

  localparam int FAULT_W      = WHEELS * WHEEL_FAULT_W;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    action_t              action;
    logic [WHEEL_W-1:0]   wheel;
    logic                 run_flag;
    logic [VALUE_W-1:0]   value;
    logic [FAULT_W-1:0]   faults;
    logic [GEN_W-1:0]     gen;
  } wheel_event_t;

  typedef struct packed {
    logic [WHEEL_W-1:0]   wheel;
    logic                 status;
    logic                 enable;
    logic                 reset_error;
    logic                 ack_error;
    logic [SPEED_W-1:0]   speed;
    logic [TORQUE_W-1:0]  torque_pos;
    logic [VALUE_W-1:0]   torque_neg;
    logic                 fault;
  } setpoint_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      event_valid = 1'b0;
  logic                      event_ready;
  logic [2:0]                action = '0;
  logic [WHEEL_W-1:0]        wheel = '0;
  logic                      run_flag = 1'b0;
  logic signed [VALUE_W-1:0] value = '0;
  logic [FAULT_W-1:0]        wheel_faults = '0;
  logic [GEN_W-1:0]          general_faults = '0;
  logic                      setpoint_valid;
  logic                      setpoint_ready = 1'b0;
  logic [WHEEL_W-1:0]        out_wheel;
  logic                      status;
  logic                      enable;
  logic                      reset_error;
  logic                      ack_error;
  logic [SPEED_W-1:0]        speed_setpoint;
  logic [TORQUE_W-1:0]       torque_pos;
  logic signed [VALUE_W-1:0] torque_neg;
  logic                      fault_latched;

  inverter_wheel_command_supervisor uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .event_valid(event_valid), .event_ready(event_ready),
    .action(action), .wheel(wheel), .run_flag(run_flag), .value(value),
    .wheel_faults(wheel_faults), .general_faults(general_faults),
    .setpoint_valid(setpoint_valid), .setpoint_ready(setpoint_ready),
    .out_wheel(out_wheel), .status(status), .enable(enable),
    .reset_error(reset_error), .ack_error(ack_error),
    .speed_setpoint(speed_setpoint), .torque_pos(torque_pos), .torque_neg(torque_neg),
    .fault_latched(fault_latched)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wheel_event_t events_pending[$];
  setpoint_t    setpoints_due[$];
  wheel_event_t cur_event;
  int           send_gap = 0;
  int           sink_stall = 0;
  int           send_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           cycles = 0;
  int           accepted = 0;
  int           checked = 0;
  int           reg_writes = 0;
  int           mismatches = 0;

  logic [WHEELS-1:0]   cfg_active = RST_ACTIVE_MASK;
  logic [SPEED_W-1:0]  cfg_max_speed = RST_MAX_SPEED;
  logic [TORQUE_W-1:0] cfg_max_torque = RST_MAX_TORQUE;
  logic [SLEW_W-1:0]   cfg_slew = RST_SLEW_STEP;

  logic                is_armed[WHEELS];
  logic                is_faulted[WHEELS];
  logic                is_running[WHEELS];
  logic                ack_owed[WHEELS];
  logic                reset_owed[WHEELS];
  logic [SPEED_W-1:0]  speed_target[WHEELS];
  logic [TORQUE_W-1:0] torque_cap[WHEELS];
  logic [CMD_W-1:0]    speed_cmd[WHEELS];

  initial begin
    for (int k = 0; k < WHEELS; k++) begin
      is_armed[k] = 1'b0;
      is_faulted[k] = 1'b0;
      is_running[k] = 1'b0;
      ack_owed[k] = 1'b0;
      reset_owed[k] = 1'b0;
      speed_target[k] = DEFAULT_RUN_SPEED;
      torque_cap[k] = DEFAULT_TORQUE;
      speed_cmd[k] = '0;
    end
  end

  function automatic void apply_event(wheel_event_t ev);
    setpoint_t           sp;
    logic [CMD_W-1:0]    goal;
    logic [CMD_W:0]      raised;
    logic [TORQUE_W-1:0] cap;
    logic [SPEED_W-1:0]  level;
    logic [GEN_W-1:0]    bus_mask;
    int                  w;
    w = ev.wheel;
    if (ev.action == ACT_TICK) begin
      sp = '0;
      sp.wheel = ev.wheel;
      if (!cfg_active[w]) begin
        sp.status = 1'b1;
      end else begin
        sp.enable = is_armed[w] && !is_faulted[w];
        goal = (is_running[w] && sp.enable) ? {speed_target[w], FRAC_BITS'(0)} : '0;
        if (speed_cmd[w] < goal) begin
          raised = {1'b0, speed_cmd[w]} + {1'b0, cfg_slew};
          speed_cmd[w] = (raised < {1'b0, goal}) ? raised[CMD_W-1:0] : goal;
        end else if (speed_cmd[w] > goal) begin
          speed_cmd[w] = (speed_cmd[w] - goal > cfg_slew) ? speed_cmd[w] - cfg_slew : goal;
        end
        sp.reset_error = reset_owed[w];
        sp.ack_error = ack_owed[w];
        ack_owed[w] = 1'b0;
        reset_owed[w] = 1'b0;
        sp.speed = speed_cmd[w][CMD_W-1:FRAC_BITS];
        sp.torque_pos = torque_cap[w];
        sp.torque_neg = VALUE_W'(0) - VALUE_W'(torque_cap[w]);
        sp.fault = is_faulted[w];
      end
      setpoints_due.push_back(sp);
    end else if (ev.action == ACT_ERROR) begin
      for (int k = 0; k < WHEELS; k++) begin
        bus_mask = (k < 2) ? 6'b001111 : 6'b110011;
        if (cfg_active[k] && !is_faulted[k] &&
            ((|ev.faults[k*WHEEL_FAULT_W +: WHEEL_FAULT_W]) || (|(ev.gen & bus_mask)))) begin
          is_faulted[k] = 1'b1;
          is_running[k] = 1'b0;
        end
      end
    end else if (cfg_active[w]) begin
      cap = (ev.action == ACT_SET_SPEED) ? cfg_max_speed : cfg_max_torque;
      level = ev.value[VALUE_W-1] ? '0 : ev.value[VALUE_W-2:0];
      if (level > cap) level = cap;
      case (ev.action)
        ACT_ARM: begin
          is_faulted[w] = 1'b0;
          ack_owed[w] = 1'b1;
          reset_owed[w] = 1'b1;
          is_armed[w] = 1'b1;
        end
        ACT_DISARM: begin
          is_running[w] = 1'b0;
          is_armed[w] = 1'b0;
        end
        ACT_SET_RUN:    is_running[w] = ev.run_flag;
        ACT_TOGGLE_RUN: is_running[w] = !is_running[w];
        ACT_SET_SPEED:  speed_target[w] = level;
        default:        torque_cap[w] = level;
      endcase
    end
  endfunction

  function automatic void queue_event(action_t act, int w, logic flag = 1'b0,
                                      logic [VALUE_W-1:0] val = '0,
                                      logic [FAULT_W-1:0] wf = '0, logic [GEN_W-1:0] gf = '0);
    wheel_event_t ev;
    ev.action = act;
    ev.wheel = WHEEL_W'(w);
    ev.run_flag = flag;
    ev.value = val;
    ev.faults = wf;
    ev.gen = gf;
    events_pending.push_back(ev);
  endfunction

  function automatic wheel_event_t random_event();
    wheel_event_t ev;
    int           pick;
    pick = $urandom_range(0, 99);
    ev.wheel = WHEEL_W'($urandom_range(0, WHEELS - 1));
    ev.run_flag = 1'($urandom_range(0, 1));
    ev.value = VALUE_W'($urandom);
    ev.faults = FAULT_W'({$urandom, $urandom});
    ev.gen = GEN_W'($urandom);
    if (pick < 35) begin
      ev.action = ACT_TICK;
    end else if (pick < 47) begin
      ev.action = ACT_ERROR;
      case ($urandom_range(0, 3))
        0, 1: begin
          ev.faults = '0;
          ev.gen = '0;
        end
        2: begin
          ev.faults = '0;
          ev.gen = '0;
          if ($urandom_range(0, 1) == 1) ev.faults = FAULT_W'(1) << $urandom_range(0, FAULT_W - 1);
          else ev.gen = GEN_W'(1) << $urandom_range(0, GEN_W - 1);
        end
        default: ;
      endcase
    end else if (pick < 57) begin
      ev.action = ACT_ARM;
    end else if (pick < 62) begin
      ev.action = ACT_DISARM;
    end else if (pick < 72) begin
      ev.action = ACT_SET_RUN;
    end else if (pick < 77) begin
      ev.action = ACT_TOGGLE_RUN;
    end else begin
      ev.action = (pick < 90) ? ACT_SET_SPEED : ACT_SET_TORQUE;
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          case ($urandom_range(0, 3))
            0: ev.value = 16'h8000;
            1: ev.value = 16'hffff;
            2: ev.value = 16'h0000;
            default: ev.value = 16'h7fff;
          endcase
        end
        default: ev.value = VALUE_W'($urandom_range(0, 3000));
      endcase
    end
    return ev;
  endfunction

  // event driver
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      event_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = event_valid;
      if (event_valid && event_ready) begin
        apply_event(cur_event);
        accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (events_pending.size() != 0) begin
          cur_event = events_pending.pop_front();
          action <= cur_event.action;
          wheel <= cur_event.wheel;
          run_flag <= cur_event.run_flag;
          value <= cur_event.value;
          wheel_faults <= cur_event.faults;
          general_faults <= cur_event.gen;
          next_valid = 1'b1;
          if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 4);
        end
      end
      event_valid <= next_valid;
    end
  end

  task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("setpoint %0d %s: expected %0d, got %0d", checked, fname, want, got);
    end
  endtask

  // setpoint monitor
  always @(posedge clk) begin
    setpoint_t want;
    if (rst) begin
      setpoint_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (setpoint_valid && setpoint_ready) begin
        if (setpoints_due.size() == 0) begin
          compare_field("unexpected transaction, out_wheel", 32'hffffffff, 32'(out_wheel));
        end else begin
          want = setpoints_due.pop_front();
          compare_field("out_wheel", 32'(want.wheel), 32'(out_wheel));
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("enable", 32'(want.enable), 32'(enable));
          compare_field("reset_error", 32'(want.reset_error), 32'(reset_error));
          compare_field("ack_error", 32'(want.ack_error), 32'(ack_error));
          compare_field("speed_setpoint", 32'(want.speed), 32'(speed_setpoint));
          compare_field("torque_pos", 32'(want.torque_pos), 32'(torque_pos));
          compare_field("torque_neg", 32'(want.torque_neg), 32'(torque_neg[VALUE_W-1:0]));
          compare_field("fault_latched", 32'(want.fault), 32'(fault_latched));
          checked++;
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        setpoint_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        sink_stall = $urandom_range(0, 3);
        setpoint_ready <= 1'b0;
      end else begin
        setpoint_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < LIMIT_CYCLES) @(negedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE_MASK: cfg_active = data[WHEELS-1:0];
      REG_MAX_SPEED:   cfg_max_speed = data[SPEED_W-1:0];
      REG_MAX_TORQUE:  cfg_max_torque = data[TORQUE_W-1:0];
      default:         cfg_slew = data[SLEW_W-1:0];
    endcase
    reg_writes++;
  endtask

  task automatic program_registers(logic [WHEELS-1:0] mask, logic [SPEED_W-1:0] spd,
                                   logic [TORQUE_W-1:0] trq, logic [SLEW_W-1:0] slew);
    write_reg(REG_ACTIVE_MASK, DATA_W'(mask));
    write_reg(REG_MAX_SPEED, DATA_W'(spd));
    write_reg(REG_MAX_TORQUE, DATA_W'(trq));
    write_reg(REG_SLEW_STEP, DATA_W'(slew));
    @(negedge clk);
  endtask

  // hold until every event is taken and every setpoint seen, then let the pipeline settle
  task automatic drain();
    while (events_pending.size() != 0 || event_valid || setpoints_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 30;
    sink_idle_pct = 30;
    for (int w = 0; w < WHEELS; w++) queue_event(ACT_TICK, w);
    drain();

    program_registers(4'b1011, '1, '1, '1);
    queue_event(ACT_ARM, 0);
    queue_event(ACT_SET_SPEED, 0, 1'b0, 16'h7fff);
    queue_event(ACT_SET_TORQUE, 0, 1'b0, 16'h8000);
    queue_event(ACT_SET_RUN, 0, 1'b1);
    queue_event(ACT_TICK, 0);
    queue_event(ACT_SET_TORQUE, 1, 1'b0, 16'h7fff);
    queue_event(ACT_SET_SPEED, 1, 1'b0, 16'hffff);
    queue_event(ACT_ARM, 1);
    queue_event(ACT_TOGGLE_RUN, 1);
    queue_event(ACT_TICK, 1);
    queue_event(ACT_ERROR, 0, 1'b0, '0, '0, 6'b001000);
    queue_event(ACT_TICK, 0);
    queue_event(ACT_TICK, 3);
    queue_event(ACT_ERROR, 0, 1'b0, '0, '0, 6'b100000);
    queue_event(ACT_TICK, 3);
    queue_event(ACT_TICK, 2);
    queue_event(ACT_ERROR, 0, 1'b0, '0, FAULT_W'(11'h7ff) << (2 * WHEEL_FAULT_W));
    queue_event(ACT_ARM, 0);
    queue_event(ACT_TICK, 0);
    queue_event(ACT_DISARM, 0);
    queue_event(ACT_ERROR, 1, 1'b1, 16'h7fff, '1, '1);
    queue_event(ACT_TICK, 1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: program_registers(4'hf, 15'd20000, 15'd210, 23'd25600);
        1: program_registers(4'hf, '1, '1, '1);
        2: program_registers(4'($urandom_range(1, 15)), 15'($urandom), 15'($urandom), '0);
        3: program_registers(4'hf, '0, '0, 23'd1);
        5: program_registers(4'hf, 15'($urandom), 15'($urandom), 23'($urandom));
        default:
          program_registers((ph == 8) ? 4'hf : 4'($urandom_range(1, 15)), 15'($urandom),
                            15'($urandom_range(0, 600)), 23'($urandom_range(1, 60000)));
      endcase
      send_idle_pct = (ph == 8) ? 0 : (ph % 3) * 25;
      sink_idle_pct = (ph == 8) ? 0 : ((ph + 1) % 3) * 25;
      for (int n = 0; n < 100; n++) events_pending.push_back(random_event());
      drain();
    end

    if (setpoints_due.size() != 0) begin
      mismatches++;
      $display("%0d expected setpoints never arrived", setpoints_due.size());
    end
    $display("%0d events taken, %0d setpoints checked, %0d register writes, %0d mismatches",
             accepted, checked, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
